/* hw/rtl/cts_pkg.sv */
// Shared types, constants and helper functions of the C token scanner.
`default_nettype none
package cts_pkg;
  localparam int KeywordChars = 7;
  localparam int LengthBits = 16;
  localparam int LineBits = 24;
  localparam int OffsetBits = 32;
  localparam int QueueDepth = 4;

  typedef enum logic [3:0] {
    M_LINE, M_GEN, M_PP, M_SLASH, M_LCOM, M_BCOM, M_MINUS, M_OP,
    M_ZERO, M_HEX0, M_HEX, M_DEC, M_ID, M_STR, M_CHR
  } mode_t;

  typedef enum logic [3:0] {
    K_ERR = 4'd0, K_DEC = 4'd1, K_HEX = 4'd2, K_TERM = 4'd3, K_ID = 4'd4,
    K_STR = 4'd5, K_CHR = 4'd6, K_PP = 4'd7, K_EOF = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE = 3'd0, E_OPEN_COMMENT = 3'd1, E_BAD_HEX = 3'd2, E_BAD_DEC = 3'd3,
    E_OPEN_STRING = 3'd4, E_OPEN_CHAR = 3'd5, E_BAD_CHAR = 3'd6
  } err_t;

  // Incoming request: one source byte and the end-of-stream mark.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic                  record_kind;
    logic [7:0]            content_byte;
    logic [3:0]            token_kind;
    logic [2:0]            error_code;
    logic [OffsetBits-1:0] token_start;
    logic [LengthBits-1:0] token_length;
    logic [LineBits-1:0]   start_line;
    logic                  last_of_run;
  } result_t;

  // Request after classification: the byte and its character class.
  typedef struct packed {
    logic       eos;
    logic [7:0] c;
    logic       is_dec;
    logic       is_hex;
    logic       is_letter;
    logic       is_blank;
    logic       is_single;
    logic       is_op;
  } class_req_t;

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    begin
      unique case (c)
        8'h6e: r = 8'd10;
        8'h74: r = 8'd9;
        8'h72: r = 8'd13;
        8'h30: r = 8'd0;
        default: r = c;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/cts_stream_if.sv */
// Valid/ready channel interface carrying a payload of a given type.
`default_nettype none
interface cts_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hw/rtl/cts_front.sv */
// Front end: accepts source bytes, classifies them and fills the request queue.
`default_nettype none
module cts_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_byte,
  input  wire logic                end_of_stream,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output cts_pkg::class_req_t      q_data
);
  localparam int Aw = $clog2(cts_pkg::QueueDepth);
  cts_pkg::class_req_t mem [cts_pkg::QueueDepth];
  logic [Aw-1:0] wr_ptr, rd_ptr;
  logic [Aw:0]   count;
  cts_pkg::class_req_t req;
  logic push, pop;

  always_comb begin
    req.c = in_byte;
    req.eos = end_of_stream | (in_byte == 8'd0);
    req.is_dec = in_byte >= 8'h30 && in_byte <= 8'h39;
    req.is_hex = req.is_dec || (in_byte >= 8'h61 && in_byte <= 8'h66)
                 || (in_byte >= 8'h41 && in_byte <= 8'h46);
    req.is_letter = (in_byte >= 8'h61 && in_byte <= 8'h7a)
                    || (in_byte >= 8'h41 && in_byte <= 8'h5a)
                    || in_byte == 8'h5f || in_byte == 8'h24;
    req.is_blank = in_byte == 8'h20 || in_byte == 8'h09 || in_byte == 8'h0d;
    req.is_single = in_byte == 8'h28 || in_byte == 8'h29 || in_byte == 8'h5b
                    || in_byte == 8'h5d || in_byte == 8'h7b || in_byte == 8'h7d
                    || in_byte == 8'h2c || in_byte == 8'h2e || in_byte == 8'h3a
                    || in_byte == 8'h3f || in_byte == 8'h3b || in_byte == 8'h5c;
    req.is_op = in_byte == 8'h3e || in_byte == 8'h3c || in_byte == 8'h2b
                || in_byte == 8'h2a || in_byte == 8'h3d || in_byte == 8'h21
                || in_byte == 8'h5e || in_byte == 8'h7c || in_byte == 8'h26
                || in_byte == 8'h25;
  end

  assign in_ready = count != (Aw+1)'(cts_pkg::QueueDepth);
  assign q_valid = count != '0;
  assign q_data = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= req;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/cts_back.sv */
// Back end: scanner state machine that turns classified requests into records.
`default_nettype none
module cts_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire cts_pkg::class_req_t q_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cts_pkg::result_t         out_data
);
  localparam int Lb = cts_pkg::LengthBits;
  localparam int Nb = cts_pkg::LineBits;
  localparam int Ob = cts_pkg::OffsetBits;
  localparam int Kc = cts_pkg::KeywordChars;
  localparam int Kw = $clog2(Kc);

  cts_pkg::mode_t mode, mode_next;
  logic [Ob-1:0] position, position_next, start_offset, start_offset_next;
  logic [Nb-1:0] line_count, line_count_next, start_line_reg, start_line_reg_next;
  logic [Lb-1:0] length_count, length_count_next;
  logic [7:0] kbuf [Kc];
  logic [7:0] kbuf_next [Kc];
  logic [7:0] pending_char, pending_char_next;
  logic escape_flag, escape_flag_next, halted, halted_next;

  // Two result slots; the second is held in a skid register when needed.
  cts_pkg::result_t r0, r1, skid, skid_next;
  logic [1:0] nres;
  logic skid_valid, skid_valid_next;
  cts_pkg::result_t ob, ob_next;
  logic ob_valid, ob_valid_next;
  logic take;

  logic [7:0] c;
  logic gen_run;
  logic [Lb-1:0] grown;

  function automatic logic [7:0] kw_ch(input int k, input int i);
    logic [55:0] s;
    begin
      unique case (k)
        0: s = {"return", 8'd0};
        1: s = {"while", 16'd0};
        2: s = {"for", 32'd0};
        3: s = {"do", 40'd0};
        4: s = "typedef";
        5: s = {"struct", 8'd0};
        6: s = {"enum", 24'd0};
        default: s = {"union", 16'd0};
      endcase
      return s[55 - 8*i -: 8];
    end
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    logic [3:0] r;
    begin
      unique case (k)
        0: r = 4'd6; 1: r = 4'd5; 2: r = 4'd3; 3: r = 4'd2;
        4: r = 4'd7; 5: r = 4'd6; 6: r = 4'd4; default: r = 4'd5;
      endcase
      return r;
    end
  endfunction

  logic is_kw;
  always_comb begin
    logic m;
    is_kw = 1'b0;
    for (int k = 0; k < 8; k++) begin
      m = (length_count == Lb'(kw_len(k))) && (int'(kw_len(k)) <= Kc);
      for (int i = 0; i < Kc; i++)
        if (i < int'(kw_len(k)) && kbuf[i] != kw_ch(k, i)) m = 1'b0;
      if (m) is_kw = 1'b1;
    end
  end

  // The back end takes a request only when both result slots are free.
  assign take = q_valid && !skid_valid && (!ob_valid || out_ready);
  assign q_ready = take;
  assign out_valid = ob_valid;
  assign out_data = ob;
  assign c = q_data.c;
  assign grown = (length_count == {Lb{1'b1}}) ? length_count : length_count + 1'b1;

  always_comb begin
    cts_pkg::result_t tok;
    cts_pkg::result_t cont;
    cts_pkg::result_t res [2];
    logic [1:0] n;
    logic [Lb-1:0] len_use;
    logic [Ob-1:0] so_use;
    logic [Nb-1:0] sl_use;
    logic emit_tok, emit_err, emit_cont, keyword;
    cts_pkg::kind_t tk;
    cts_pkg::err_t ec;

    mode_next = mode;
    position_next = position;
    line_count_next = line_count;
    start_offset_next = start_offset;
    start_line_reg_next = start_line_reg;
    length_count_next = length_count;
    kbuf_next = kbuf;
    pending_char_next = pending_char;
    escape_flag_next = escape_flag;
    halted_next = halted;
    gen_run = 1'b0;
    n = 2'd0;
    res[0] = '0;
    res[1] = '0;
    emit_tok = 1'b0;
    emit_err = 1'b0;
    emit_cont = 1'b0;
    keyword = 1'b0;
    tk = cts_pkg::K_TERM;
    ec = cts_pkg::E_NONE;
    len_use = length_count;
    cont = '0;
    tok = '0;
    so_use = '0;
    sl_use = '0;

    if (q_data.eos) begin
      if (!halted) begin
        unique case (mode)
          cts_pkg::M_PP: begin emit_tok = 1'b1; tk = cts_pkg::K_PP; end
          cts_pkg::M_SLASH, cts_pkg::M_MINUS, cts_pkg::M_OP: emit_tok = 1'b1;
          cts_pkg::M_ZERO, cts_pkg::M_DEC: begin emit_tok = 1'b1; tk = cts_pkg::K_DEC; end
          cts_pkg::M_HEX0: begin emit_err = 1'b1; ec = cts_pkg::E_BAD_HEX; end
          cts_pkg::M_HEX: begin emit_tok = 1'b1; tk = cts_pkg::K_HEX; end
          cts_pkg::M_ID: begin emit_tok = 1'b1; keyword = 1'b1; end
          cts_pkg::M_BCOM: begin emit_err = 1'b1; ec = cts_pkg::E_OPEN_COMMENT; end
          cts_pkg::M_STR: begin emit_err = 1'b1; ec = cts_pkg::E_OPEN_STRING; end
          cts_pkg::M_CHR: begin emit_err = 1'b1; ec = cts_pkg::E_OPEN_CHAR; end
          default: ;
        endcase
      end
      if (keyword) tk = is_kw ? cts_pkg::K_TERM : cts_pkg::K_ID;
      if (emit_tok || emit_err) begin
        tok = '0;
        tok.record_kind = 1'b1;
        tok.token_kind = emit_err ? cts_pkg::K_ERR : tk;
        tok.error_code = ec;
        tok.token_start = start_offset;
        tok.token_length = length_count;
        tok.start_line = start_line_reg;
        res[n[0]] = tok;
        n = n + 2'd1;
      end
      tok = '0;
      tok.record_kind = 1'b1;
      tok.token_kind = cts_pkg::K_EOF;
      tok.token_start = position;
      tok.start_line = line_count;
      res[n[0]] = tok;
      n = n + 2'd1;
      mode_next = cts_pkg::M_LINE;
      position_next = '0;
      line_count_next = Nb'(1);
      start_offset_next = '0;
      start_line_reg_next = Nb'(1);
      length_count_next = '0;
      for (int i = 0; i < Kc; i++) kbuf_next[i] = '0;
      pending_char_next = '0;
      escape_flag_next = 1'b0;
      halted_next = 1'b0;
    end else if (!halted) begin
      // Phase 1: the current mode either consumes the byte or closes a token.
      unique case (mode)
        cts_pkg::M_LINE: begin
          if (c == 8'h20 || c == 8'h09 || c == 8'h0a) ;
          else if (c == 8'h23) begin
            mode_next = cts_pkg::M_PP;
            start_offset_next = position;
            start_line_reg_next = line_count;
            length_count_next = Lb'(1);
          end else gen_run = 1'b1;
        end
        cts_pkg::M_PP: begin
          if (c == 8'h0a) begin
            emit_tok = 1'b1; tk = cts_pkg::K_PP; mode_next = cts_pkg::M_LINE;
          end else length_count_next = grown;
        end
        cts_pkg::M_SLASH: begin
          if (c == 8'h2f) mode_next = cts_pkg::M_LCOM;
          else if (c == 8'h2a) begin
            length_count_next = grown; pending_char_next = '0;
            mode_next = cts_pkg::M_BCOM;
          end else if (c == 8'h3d) begin
            length_count_next = grown; len_use = grown; emit_tok = 1'b1;
            mode_next = cts_pkg::M_GEN;
          end else begin emit_tok = 1'b1; gen_run = 1'b1; end
        end
        cts_pkg::M_LCOM: if (c == 8'h0a) mode_next = cts_pkg::M_LINE;
        cts_pkg::M_BCOM: begin
          length_count_next = grown;
          if (c == 8'h2f && pending_char == 8'h2a) mode_next = cts_pkg::M_GEN;
          else pending_char_next = c;
        end
        cts_pkg::M_MINUS, cts_pkg::M_OP: begin
          if (c == 8'h3d || (c == 8'h3e && mode == cts_pkg::M_MINUS)) begin
            length_count_next = grown; len_use = grown; emit_tok = 1'b1;
            mode_next = cts_pkg::M_GEN;
          end else begin emit_tok = 1'b1; gen_run = 1'b1; end
        end
        cts_pkg::M_ZERO, cts_pkg::M_DEC: begin
          if (mode == cts_pkg::M_ZERO && c == 8'h78) begin
            length_count_next = grown; mode_next = cts_pkg::M_HEX0;
          end else if (q_data.is_dec) begin
            length_count_next = grown; mode_next = cts_pkg::M_DEC;
          end else if (q_data.is_letter) begin
            length_count_next = grown; len_use = grown;
            emit_err = 1'b1; ec = cts_pkg::E_BAD_DEC;
          end else begin emit_tok = 1'b1; tk = cts_pkg::K_DEC; gen_run = 1'b1; end
        end
        cts_pkg::M_HEX0: begin
          length_count_next = grown;
          if (q_data.is_hex) mode_next = cts_pkg::M_HEX;
          else begin len_use = grown; emit_err = 1'b1; ec = cts_pkg::E_BAD_HEX; end
        end
        cts_pkg::M_HEX: begin
          if (q_data.is_hex) length_count_next = grown;
          else if (q_data.is_letter) begin
            length_count_next = grown; len_use = grown;
            emit_err = 1'b1; ec = cts_pkg::E_BAD_HEX;
          end else begin emit_tok = 1'b1; tk = cts_pkg::K_HEX; gen_run = 1'b1; end
        end
        cts_pkg::M_ID: begin
          if (q_data.is_letter || q_data.is_dec) begin
            if (length_count < Lb'(Kc)) kbuf_next[length_count[Kw-1:0]] = c;
            length_count_next = grown;
          end else begin emit_tok = 1'b1; keyword = 1'b1; gen_run = 1'b1; end
        end
        cts_pkg::M_STR, cts_pkg::M_CHR: begin
          length_count_next = grown;
          cont = '0;
          if (escape_flag) begin
            emit_cont = 1'b1; cont.content_byte = cts_pkg::unescape(c);
            escape_flag_next = 1'b0;
          end else if (c == 8'h5c) escape_flag_next = 1'b1;
          else if (c == ((mode == cts_pkg::M_STR) ? 8'h22 : 8'h27)) begin
            len_use = grown; emit_tok = 1'b1;
            tk = (mode == cts_pkg::M_STR) ? cts_pkg::K_STR : cts_pkg::K_CHR;
            mode_next = cts_pkg::M_GEN;
          end else begin emit_cont = 1'b1; cont.content_byte = c; end
        end
        default: gen_run = 1'b1;
      endcase
      if (keyword) tk = is_kw ? cts_pkg::K_TERM : cts_pkg::K_ID;
      if (emit_tok || emit_err) begin
        tok = '0;
        tok.record_kind = 1'b1;
        tok.token_kind = emit_err ? cts_pkg::K_ERR : tk;
        tok.error_code = ec;
        tok.token_start = start_offset;
        tok.token_length = len_use;
        tok.start_line = start_line_reg;
        res[n[0]] = tok;
        n = n + 2'd1;
        if (emit_err) halted_next = 1'b1;
      end
      if (emit_cont) begin
        res[n[0]] = cont;
        n = n + 2'd1;
      end
      // Phase 2: the byte starts something new in general mode.
      if (gen_run) begin
        so_use = position;
        sl_use = line_count;
        mode_next = cts_pkg::M_GEN;
        if (c == 8'h0a) mode_next = cts_pkg::M_LINE;
        else if (q_data.is_blank) ;
        else begin
          start_offset_next = so_use;
          start_line_reg_next = sl_use;
          length_count_next = Lb'(1);
          tok = '0;
          tok.record_kind = 1'b1;
          tok.token_start = so_use;
          tok.token_length = Lb'(1);
          tok.start_line = sl_use;
          if (c == 8'h2f) mode_next = cts_pkg::M_SLASH;
          else if (q_data.is_single) begin
            tok.token_kind = cts_pkg::K_TERM;
            res[n[0]] = tok;
            n = n + 2'd1;
          end else if (c == 8'h2d) mode_next = cts_pkg::M_MINUS;
          else if (q_data.is_op) mode_next = cts_pkg::M_OP;
          else if (c == 8'h30) mode_next = cts_pkg::M_ZERO;
          else if (q_data.is_dec) mode_next = cts_pkg::M_DEC;
          else if (q_data.is_letter) begin
            mode_next = cts_pkg::M_ID; kbuf_next[0] = c;
          end else if (c == 8'h22) begin
            mode_next = cts_pkg::M_STR; escape_flag_next = 1'b0;
          end else if (c == 8'h27) begin
            mode_next = cts_pkg::M_CHR; escape_flag_next = 1'b0;
          end else begin
            tok.token_kind = cts_pkg::K_ERR;
            tok.error_code = cts_pkg::E_BAD_CHAR;
            res[n[0]] = tok;
            n = n + 2'd1;
            halted_next = 1'b1;
          end
        end
      end
      position_next = position + 1'b1;
      if (c == 8'h0a && line_count != {Nb{1'b1}}) line_count_next = line_count + 1'b1;
    end
    if (n == 2'd1) res[0].last_of_run = 1'b1;
    if (n == 2'd2) res[1].last_of_run = 1'b1;
    r0 = res[0];
    r1 = res[1];
    nres = n;
  end

  always_comb begin
    ob_next = ob;
    ob_valid_next = ob_valid && !out_ready;
    skid_next = skid;
    skid_valid_next = skid_valid;
    if (skid_valid && (!ob_valid || out_ready)) begin
      ob_next = skid;
      ob_valid_next = 1'b1;
      skid_valid_next = 1'b0;
    end else if (take && nres != 2'd0) begin
      ob_next = r0;
      ob_valid_next = 1'b1;
      if (nres == 2'd2) begin
        skid_next = r1;
        skid_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ob <= ob_next;
    skid <= skid_next;
    if (rst) begin
      ob_valid <= 1'b0;
      skid_valid <= 1'b0;
      mode <= cts_pkg::M_LINE;
      position <= '0;
      line_count <= Nb'(1);
      start_offset <= '0;
      start_line_reg <= Nb'(1);
      length_count <= '0;
      for (int i = 0; i < Kc; i++) kbuf[i] <= '0;
      pending_char <= '0;
      escape_flag <= 1'b0;
      halted <= 1'b0;
    end else begin
      ob_valid <= ob_valid_next;
      skid_valid <= skid_valid_next;
      if (take) begin
        mode <= mode_next;
        position <= position_next;
        line_count <= line_count_next;
        start_offset <= start_offset_next;
        start_line_reg <= start_line_reg_next;
        length_count <= length_count_next;
        kbuf <= kbuf_next;
        pending_char <= pending_char_next;
        escape_flag <= escape_flag_next;
        halted <= halted_next;
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/c_token_scanner_core.sv */
// Top level of the C token scanner: request queue front end and scanner back end.
// A byte's first record passes through the request queue and the output register.
// Throughput: one byte per cycle while out_ready is high and each byte yields at most
// one record; a byte with two records holds the back end until its skid slot drains.
// The rate is set by the back-end state update, one byte per cycle.
// Reset: synchronous rst clears the queue, scanner state and output registers.
`default_nettype none
module c_token_scanner_core (
  input wire logic clk,
  input wire logic rst,
  cts_stream_if.sink   in_req,
  cts_stream_if.source out_rec
);
  logic q_valid, q_ready;
  cts_pkg::class_req_t q_data;
  cts_pkg::result_t res;

  cts_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_req.valid), .in_ready(in_req.ready),
    .in_byte(in_req.payload.in_byte), .end_of_stream(in_req.payload.end_of_stream),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  cts_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_rec.valid), .out_ready(out_rec.ready), .out_data(res)
  );

  assign out_rec.payload = res;
endmodule
`default_nettype wire
